// File: rtl/vehicle_acceleration_limiter_defines.svh
// Assertion macros shared by the acceleration limiter RTL.
`ifndef VEHICLE_ACCELERATION_LIMITER_DEFINES_SVH
`define VEHICLE_ACCELERATION_LIMITER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define VAL_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define VAL_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/val_pkg.sv
// Types and constants shared by the acceleration limiter modules.
package val_pkg;

	// Fixed-point constants
	localparam logic [15:0] G_Q10      = 16'd10045;    // 9.81 m/s^2 in Q5.10
	localparam logic [19:0] RPM_K_Q16  = 20'd625823;   // 60/(2*pi) in Q16
	localparam logic [23:0] TORQUE_CAP = 24'hFF_FFFF;
	localparam logic [20:0] T4_SCALE   = 21'd1280000;  // 5000 rpm * 256
	localparam logic [13:0] RPM_P1     = 14'd1350;
	localparam logic [13:0] RPM_P2     = 14'd4600;
	localparam logic [13:0] RPM_P3     = 14'd5000;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GEAR_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AXLE_RADIUS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RPM      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TORQUE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MASS         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAG         = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLLING      = 3'd7;

	// Item opcodes
	localparam logic OP_WRITE_GEAR = 1'b0;
	localparam logic OP_COMPUTE    = 1'b1;

	// Shared multiplier operand widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Shared divider widths
	localparam int DIV_N_W = 42;
	localparam int DIV_D_W = 22;
	localparam int DIV_C_W = 6;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] num;
		logic [DIV_D_W-1:0] den;
		logic [DIV_C_W-1:0] nbits;   // quotient bits to produce
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quo;
	} div_rsp_t;

endpackage

// File: rtl/vehicle_acceleration_limiter.sv
// Vehicle acceleration limiter: gear table, sequencer and output register.
// An op 0 item writes one gear ratio when its index is in range, and its all-zero result
// is loaded into the output register from S_DONE once that register is free. An op 1 item
// runs every product but the friction one through one shared 32x24 multiplier and every
// quotient through one bit-serial divider that yields one quotient bit per cycle (33 bits
// for the top-of-curve torque, 20 per gear interpolation, 38 for the wheel term and 34 for
// the drag term). A zero max rpm skips the top-of-curve division. While an item is at work
// in_stall stays high; a finished result sits in the output register and the next item
// may be accepted before it is taken.
`include "vehicle_acceleration_limiter_defines.svh"

module vehicle_acceleration_limiter #(
	parameter int MAX_GEARS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input items
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic [3:0]                       gear_index,
	input  logic [15:0]                      gear_ratio,
	input  logic                             acting,
	input  logic signed [15:0]               requested_accel,
	input  logic [15:0]                      velocity,
	input  logic [9:0]                       road_friction,
	// result items
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [15:0]               limited_accel,
	output logic signed [15:0]               accel_limit,
	output logic signed [15:0]               decel_limit,
	output logic                             no_usable_gear,
	output logic                             acting_out,
	// configuration writes
	input  logic                             cfg_we,
	input  logic [val_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                      cfg_data
);
	import val_pkg::*;

	localparam int IW = $clog2(MAX_GEARS);

	typedef enum logic [4:0] {
		S_IDLE, S_T4_MUL, S_T4_DIV, S_T4_WAIT, S_VA_MUL, S_VA_SAVE,
		S_GEAR_P, S_GEAR_LO, S_GEAR_HI, S_GEAR_RPM, S_INT_DIV, S_INT_WAIT,
		S_TQ_MUL, S_TQ_CMP, S_NEXT_GEAR, S_WHL_LO, S_WHL_HI, S_WHL_DIV,
		S_WHL_WAIT, S_DRG_VV, S_DRG_M, S_DRG_DIV, S_DRG_WAIT, S_DONE
	} state_t;

	// Configuration registers
	logic [3:0]  gear_count_q;
	logic [15:0] axle_q;
	logic [13:0] min_rpm_q;
	logic [13:0] max_rpm_q;
	logic [11:0] max_tq_q;
	logic [15:0] mass_q;
	logic [15:0] drag_q;
	logic [14:0] rolling_q;

	logic [15:0] gear_tbl_q [MAX_GEARS];

	// Sequencer state
	state_t             state_q;
	logic [IW-1:0]      gi_q;
	logic               op_q;
	logic [15:0]        vel_q;
	logic [9:0]         rf_q;
	logic signed [15:0] held_req_q;
	logic               held_act_q;
	logic [23:0]        t4_q;
	logic [31:0]        va_q;
	logic [39:0]        p_q;
	logic [51:0]        lo_q;
	logic [23:0]        ta_q;
	logic               neg_q;
	logic [21:0]        seg_len_q;
	logic [23:0]        tq_q;
	logic [39:0]        best_q;
	logic               found_q;
	logic [37:0]        wheel_q;
	logic signed [15:0] accel_q;

	// Output register
	logic               out_valid_q;
	logic signed [15:0] limited_accel_q;
	logic signed [15:0] accel_limit_q;
	logic signed [15:0] decel_limit_q;
	logic               no_usable_gear_q;
	logic               acting_out_q;

	// Shared units
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;
	div_req_t           dreq;
	div_rsp_t           drsp;

	val_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	val_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	logic        accept;
	logic [4:0]  gcnt;
	logic        last_gear;
	logic [15:0] ratio;
	logic [15:0] mass1;
	logic        idx_ok;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign gcnt      = ({1'b0, gear_count_q} > 5'(MAX_GEARS)) ? 5'(MAX_GEARS)
	                                                          : {1'b0, gear_count_q};
	assign last_gear = (5'(gi_q) + 5'd1) >= gcnt;
	assign ratio     = gear_tbl_q[gi_q];
	assign mass1     = (mass_q == '0) ? 16'd1 : mass_q;
	assign idx_ok    = (gear_index != 4'd0) && ({1'b0, gear_index} <= 5'(MAX_GEARS));

	// Engine speed and torque curve segment for the current gear
	logic [59:0] rpm_sum;
	logic [23:0] rpm;
	logic [23:0] s0, s1, s3, s4;
	logic [23:0] t0, t1;
	logic        out_rng;
	logic        use_int;
	logic [23:0] direct_tq;
	logic [23:0] ta, tb, sa, sb;
	logic [24:0] tdiff;
	logic        tneg;
	logic [23:0] tmag;
	logic [23:0] span;
	logic [23:0] seg_len;

	always_comb begin
		rpm_sum   = {prod[27:0], 32'b0} + 60'(lo_q);
		rpm       = rpm_sum[59:36];
		s0        = {2'b0, min_rpm_q, 8'b0};
		s1        = {2'b0, RPM_P1, 8'b0};
		s3        = {2'b0, RPM_P3, 8'b0};
		s4        = {2'b0, max_rpm_q, 8'b0};
		t0        = 24'({max_tq_q, 7'b0});
		t1        = 24'({max_tq_q, 8'b0});
		out_rng   = (rpm > s4) || (rpm < s0);
		use_int   = 1'b0;
		direct_tq = t1;
		ta        = t0;
		tb        = t1;
		sa        = s0;
		sb        = s1;
		if (rpm <= s0) begin
			direct_tq = t0;
		end else if (rpm >= s4) begin
			direct_tq = t4_q;
		end else if (rpm <= s1) begin
			use_int = 1'b1;
		end else if (rpm <= s3) begin
			// flat middle of the curve, including the point at 4600 rpm
			direct_tq = t1;
		end else begin
			use_int = 1'b1;
			ta      = t1;
			tb      = t4_q;
			sa      = s3;
			sb      = s4;
		end
		tdiff   = {1'b0, tb} - {1'b0, ta};
		tneg    = tdiff[24];
		tmag    = tneg ? 24'(-tdiff) : tdiff[23:0];
		span    = rpm - sa;
		seg_len = sb - sa;
	end

	// Wheel torque product reduced by 2^18
	logic [55:0] whl_sum;
	assign whl_sum = {prod[23:0], 32'b0} + 56'(lo_q[47:0]);

	// Interpolation result, clamped to the torque range
	logic [25:0] int_res;
	logic [23:0] int_tq;
	always_comb begin
		if (neg_q) begin
			int_res = {2'b0, ta_q} - {2'b0, drsp.quo[23:0]};
		end else begin
			int_res = {2'b0, ta_q} + {2'b0, drsp.quo[23:0]};
		end
		if (int_res[25]) begin
			int_tq = '0;
		end else if (int_res[24]) begin
			int_tq = TORQUE_CAP;
		end else begin
			int_tq = int_res[23:0];
		end
	end

	// Upper limit from wheel, rolling and drag terms, saturated
	logic signed [40:0] acc_full;
	logic signed [15:0] acc_sat;
	always_comb begin
		acc_full = $signed(41'(wheel_q)) - $signed(41'(rolling_q))
		         - $signed(41'(drsp.quo[33:0]));
		if (acc_full > 41'sd32767) begin
			acc_sat = 16'sd32767;
		end else if (acc_full < -41'sd32768) begin
			acc_sat = -16'sd32768;
		end else begin
			acc_sat = acc_full[15:0];
		end
	end

	// Result fields for a compute item
	logic [23:0]        dprod;
	logic [16:0]        dmag;
	logic signed [15:0] decel_v;
	logic signed [15:0] accel_v;
	logic signed [15:0] lim_v;
	always_comb begin
		dprod   = 24'(rf_q) * 24'(G_Q10);
		dmag    = 17'(dprod[23:8]);
		decel_v = (dmag > 17'd32768) ? -16'sd32768 : 16'(-dmag);
		accel_v = found_q ? accel_q : $signed(G_Q10);
		lim_v   = held_req_q;
		if (lim_v > accel_v) begin
			lim_v = accel_v;
		end
		if (lim_v < decel_v) begin
			lim_v = decel_v;
		end
	end

	// Operands of the shared multiplier per state
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_T4_MUL: begin
				mul_a = MUL_A_W'(max_tq_q);
				mul_b = MUL_B_W'(T4_SCALE);
			end
			S_VA_MUL: begin
				mul_a = MUL_A_W'(vel_q);
				mul_b = MUL_B_W'(axle_q);
			end
			S_GEAR_P: begin
				mul_a = va_q;
				mul_b = MUL_B_W'(ratio);
			end
			S_GEAR_LO: begin
				mul_a = prod[31:0];
				mul_b = MUL_B_W'(RPM_K_Q16);
			end
			S_GEAR_HI: begin
				mul_a = MUL_A_W'(p_q[39:32]);
				mul_b = MUL_B_W'(RPM_K_Q16);
			end
			S_GEAR_RPM: begin
				mul_a = MUL_A_W'(tmag);
				mul_b = span;
			end
			S_TQ_MUL: begin
				mul_a = MUL_A_W'(tq_q);
				mul_b = MUL_B_W'(ratio);
			end
			S_WHL_LO: begin
				mul_a = best_q[31:0];
				mul_b = MUL_B_W'(axle_q);
			end
			S_WHL_HI: begin
				mul_a = MUL_A_W'(best_q[39:32]);
				mul_b = MUL_B_W'(axle_q);
			end
			S_DRG_VV: begin
				mul_a = MUL_A_W'(vel_q);
				mul_b = MUL_B_W'(vel_q);
			end
			S_DRG_M: begin
				mul_a = prod[31:0];
				mul_b = MUL_B_W'(drag_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Divider requests per state
	always_comb begin
		dreq = '0;
		case (state_q)
			S_T4_DIV: begin
				dreq.start = (max_rpm_q != '0);
				dreq.num   = DIV_N_W'(prod[32:0]);
				dreq.den   = DIV_D_W'(max_rpm_q);
				dreq.nbits = DIV_C_W'(33);
			end
			S_INT_DIV: begin
				dreq.start = 1'b1;
				dreq.num   = prod[DIV_N_W-1:0];
				dreq.den   = seg_len_q;
				dreq.nbits = DIV_C_W'(20);
			end
			S_WHL_DIV: begin
				dreq.start = 1'b1;
				dreq.num   = DIV_N_W'(whl_sum[55:18]);
				dreq.den   = DIV_D_W'(mass1);
				dreq.nbits = DIV_C_W'(38);
			end
			S_DRG_DIV: begin
				dreq.start = 1'b1;
				dreq.num   = DIV_N_W'(prod[47:14]);
				dreq.den   = DIV_D_W'(mass1);
				dreq.nbits = DIV_C_W'(34);
			end
			default: begin
				dreq = '0;
			end
		endcase
	end

	// Configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_count_q <= 4'd1;
			axle_q       <= 16'd1024;
			min_rpm_q    <= 14'd800;
			max_rpm_q    <= 14'd6000;
			max_tq_q     <= 12'd250;
			mass_q       <= 16'd1500;
			drag_q       <= 16'd205;
			rolling_q    <= 15'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GEAR_COUNT:  gear_count_q <= cfg_data[3:0];
				CFG_AXLE_RADIUS: axle_q       <= cfg_data;
				CFG_MIN_RPM:     min_rpm_q    <= cfg_data[13:0];
				CFG_MAX_RPM:     max_rpm_q    <= cfg_data[13:0];
				CFG_MAX_TORQUE:  max_tq_q     <= cfg_data[11:0];
				CFG_MASS:        mass_q       <= cfg_data;
				CFG_DRAG:        drag_q       <= cfg_data;
				CFG_ROLLING:     rolling_q    <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// Gear ratio table, written by op 0 items
	always_ff @(posedge clk) begin
		if (accept && (op == OP_WRITE_GEAR) && idx_ok) begin
			gear_tbl_q[IW'(gear_index - 4'd1)] <= gear_ratio;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gi_q        <= '0;
			op_q        <= OP_WRITE_GEAR;
			found_q     <= 1'b0;
			held_req_q  <= '0;
			held_act_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// S_DONE keeps or reloads the output itself
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= op;
						vel_q   <= velocity;
						rf_q    <= road_friction;
						gi_q    <= '0;
						found_q <= 1'b0;
						if (op == OP_COMPUTE) begin
							held_act_q <= acting;
							if (acting) begin
								held_req_q <= requested_accel;
							end
							state_q <= S_T4_MUL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_T4_MUL: state_q <= S_T4_DIV;
				S_T4_DIV: begin
					if (max_rpm_q == '0) begin
						t4_q    <= t1;
						state_q <= S_VA_MUL;
					end else begin
						state_q <= S_T4_WAIT;
					end
				end
				S_T4_WAIT: begin
					if (drsp.done) begin
						t4_q    <= (drsp.quo[41:24] != '0) ? TORQUE_CAP : drsp.quo[23:0];
						state_q <= S_VA_MUL;
					end
				end
				S_VA_MUL: state_q <= S_VA_SAVE;
				S_VA_SAVE: begin
					va_q    <= prod[31:0];
					state_q <= (gcnt == '0) ? S_DONE : S_GEAR_P;
				end
				S_GEAR_P: state_q <= S_GEAR_LO;
				S_GEAR_LO: begin
					p_q <= prod[39:0];
					// over speed: product at or beyond 2^40
					state_q <= (prod[47:40] != '0) ? S_NEXT_GEAR : S_GEAR_HI;
				end
				S_GEAR_HI: begin
					lo_q    <= prod[51:0];
					state_q <= S_GEAR_RPM;
				end
				S_GEAR_RPM: begin
					ta_q      <= ta;
					neg_q     <= tneg;
					seg_len_q <= seg_len[21:0];
					tq_q      <= direct_tq;
					if (out_rng) begin
						state_q <= S_NEXT_GEAR;
					end else if (use_int) begin
						state_q <= S_INT_DIV;
					end else begin
						state_q <= S_TQ_MUL;
					end
				end
				S_INT_DIV: state_q <= S_INT_WAIT;
				S_INT_WAIT: begin
					if (drsp.done) begin
						tq_q    <= int_tq;
						state_q <= S_TQ_MUL;
					end
				end
				S_TQ_MUL: state_q <= S_TQ_CMP;
				S_TQ_CMP: begin
					if (!found_q || (prod[39:0] > best_q)) begin
						best_q <= prod[39:0];
					end
					found_q <= 1'b1;
					state_q <= S_NEXT_GEAR;
				end
				S_NEXT_GEAR: begin
					if (last_gear) begin
						state_q <= found_q ? S_WHL_LO : S_DONE;
					end else begin
						gi_q    <= gi_q + IW'(1);
						state_q <= S_GEAR_P;
					end
				end
				S_WHL_LO: state_q <= S_WHL_HI;
				S_WHL_HI: begin
					lo_q    <= 52'(prod[47:0]);
					state_q <= S_WHL_DIV;
				end
				S_WHL_DIV: state_q <= S_WHL_WAIT;
				S_WHL_WAIT: begin
					if (drsp.done) begin
						wheel_q <= drsp.quo[37:0];
						state_q <= S_DRG_VV;
					end
				end
				S_DRG_VV:  state_q <= S_DRG_M;
				S_DRG_M:   state_q <= S_DRG_DIV;
				S_DRG_DIV: state_q <= S_DRG_WAIT;
				S_DRG_WAIT: begin
					if (drsp.done) begin
						accel_q <= acc_sat;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						if (op_q == OP_COMPUTE) begin
							limited_accel_q  <= lim_v;
							accel_limit_q    <= accel_v;
							decel_limit_q    <= decel_v;
							no_usable_gear_q <= !found_q;
							acting_out_q     <= held_act_q;
						end else begin
							limited_accel_q  <= '0;
							accel_limit_q    <= '0;
							decel_limit_q    <= '0;
							no_usable_gear_q <= 1'b0;
							acting_out_q     <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign limited_accel  = limited_accel_q;
	assign accel_limit    = accel_limit_q;
	assign decel_limit    = decel_limit_q;
	assign no_usable_gear = no_usable_gear_q;
	assign acting_out     = acting_out_q;

	`VAL_ASSERT_NEXT(a_busy_after_item, accept, in_stall, "item accepted but block not busy")
	`VAL_ASSERT_NOW(a_decel_nonpos, out_valid_q, decel_limit_q <= 16'sd0, "decel limit positive")
	`VAL_ASSERT_NOW(a_no_gear_is_g, out_valid_q && no_usable_gear_q, accel_limit_q == $signed(G_Q10), "no gear but limit is not g")
	`VAL_ASSERT_NOW(a_lim_floor, out_valid_q, limited_accel_q >= decel_limit_q, "result below decel limit")

endmodule

// File: rtl/val_mul.sv
// Shared unsigned multiplier with a registered product.
module val_mul (
	input  logic                         clk,
	input  logic [val_pkg::MUL_A_W-1:0]  a,
	input  logic [val_pkg::MUL_B_W-1:0]  b,
	output logic [val_pkg::MUL_P_W-1:0]  p
);
	import val_pkg::*;

	logic [MUL_P_W-1:0] p_q;

	// One product per cycle, read by the sequencer in the following state
	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

// File: rtl/val_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`include "vehicle_acceleration_limiter_defines.svh"

module val_div (
	input  logic               clk,
	input  logic               arst_n,
	input  val_pkg::div_req_t  req,
	output val_pkg::div_rsp_t  rsp
);
	import val_pkg::*;

	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_N_W-1:0] num_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_C_W-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [DIV_D_W:0]   trial;
	logic               fits;
	logic [DIV_D_W:0]   diff;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		trial = {rem_q, num_q[DIV_N_W-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// Control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_C_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_C_W'(1);
				if (cnt_q == DIV_C_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// leading bits above the quotient width are already below the divisor
			rem_q <= DIV_D_W'(req.num >> req.nbits);
			num_q <= req.num << (DIV_C_W'(DIV_N_W) - req.nbits);
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			num_q <= {num_q[DIV_N_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	`VAL_ASSERT_NOW(a_div_start_idle, req.start, !busy_q, "divider restarted while busy")
	`VAL_ASSERT_NOW(a_div_cnt_live, busy_q, cnt_q != '0, "divider busy with no bits left")
	`VAL_ASSERT_NEXT(a_div_done_pulse, done_q, !done_q && !busy_q, "divider done not a pulse")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the vehicle acceleration limiter.
module tb_top;
	import val_pkg::*;

	localparam longint GRAV       = 10045;
	localparam longint RPM_K      = 625823;
	localparam longint TQ_CAP     = 16777215;
	localparam int     TABLE_SIZE = 8;
	localparam int     CYCLE_CAP  = 3000000;

	typedef struct {
		logic               op;
		logic [3:0]         idx;
		logic [15:0]        ratio;
		logic               act;
		logic signed [15:0] req;
		logic [15:0]        vel;
		logic [9:0]         fric;
	} item_t;

	typedef struct {
		logic signed [15:0] lim;
		logic signed [15:0] alim;
		logic signed [15:0] dlim;
		logic               nug;
		logic               act;
	} res_t;

	typedef struct {
		item_t it;
		bit    typed;
		res_t  res;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, op, acting;
	logic [3:0] gear_index;
	logic [15:0] gear_ratio, velocity;
	logic signed [15:0] requested_accel;
	logic [9:0] road_friction;
	logic out_valid, out_stall, no_usable_gear, acting_out;
	logic signed [15:0] limited_accel, accel_limit, decel_limit;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	// predictor state
	logic [15:0]        gear_tab [TABLE_SIZE];
	logic signed [15:0] held_req;
	logic               held_act;
	longint             cfg_reg [8];
	res_t               result_q[$];

	int errors, items_sent, results_seen, cfg_writes, cycles;
	int send_idle, recv_idle, hold_cnt;
	bit hold_req;

	vehicle_acceleration_limiter dut (.*);

	// clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic longint sat16(longint x);
		if (x > 32767)
			return 32767;
		if (x < -32768)
			return -32768;
		return x;
	endfunction

	// expected result of one item; updates the gear table and held request
	function automatic res_t limit_accel(item_t it);
		res_t   r;
		longint s[5], t[5];
		longint v, p, rpm, tq, w, best, mass, cnt, d, accel, decel, lim;
		bit     found;
		r = '{default: '0};
		if (it.op == OP_WRITE_GEAR) begin
			if (it.idx >= 1 && it.idx <= TABLE_SIZE)
				gear_tab[it.idx - 1] = it.ratio;
			return r;
		end
		held_act = it.act;
		if (it.act)
			held_req = it.req;
		v = it.vel;
		mass = (cfg_reg[CFG_MASS] != 0) ? cfg_reg[CFG_MASS] : 1;
		cnt = (cfg_reg[CFG_GEAR_COUNT] > TABLE_SIZE) ? TABLE_SIZE : cfg_reg[CFG_GEAR_COUNT];
		s[0] = cfg_reg[CFG_MIN_RPM] << 8;
		s[1] = 1350 << 8;
		s[2] = 4600 << 8;
		s[3] = 5000 << 8;
		s[4] = cfg_reg[CFG_MAX_RPM] << 8;
		t[0] = cfg_reg[CFG_MAX_TORQUE] << 7;
		t[1] = cfg_reg[CFG_MAX_TORQUE] << 8;
		t[2] = t[1];
		t[3] = t[1];
		t[4] = (cfg_reg[CFG_MAX_RPM] != 0) ?
			cfg_reg[CFG_MAX_TORQUE] * 1280000 / cfg_reg[CFG_MAX_RPM] : t[1];
		found = 0;
		best = 0;
		for (int g = 1; g <= cnt; g++) begin
			p = v * cfg_reg[CFG_AXLE_RADIUS] * longint'(gear_tab[g - 1]);
			if (p >= (longint'(1) << 40))
				continue;
			rpm = (p * RPM_K) >> 36;
			if (rpm > s[4] || rpm < s[0])
				continue;
			// torque curve lookup
			if (rpm <= s[0])
				tq = t[0];
			else if (rpm >= s[4])
				tq = t[4];
			else begin
				tq = t[4];
				for (int i = 1; i < 5; i++) begin
					if (s[i] >= rpm) begin
						d = s[i] - s[i - 1];
						if (d <= 0)
							tq = t[i];
						else
							tq = t[i - 1] + (t[i] - t[i - 1]) * (rpm - s[i - 1]) / d;
						break;
					end
				end
			end
			if (tq < 0)
				tq = 0;
			if (tq > TQ_CAP)
				tq = TQ_CAP;
			w = tq * longint'(gear_tab[g - 1]);
			if (!found || w > best)
				best = w;
			found = 1;
		end
		if (found)
			accel = best * cfg_reg[CFG_AXLE_RADIUS] / (mass << 18) - cfg_reg[CFG_ROLLING]
				- cfg_reg[CFG_DRAG] * v * v / (mass << 14);
		else
			accel = GRAV;
		accel = sat16(accel);
		decel = sat16(-((longint'(it.fric) * GRAV) >> 8));
		lim = held_req;
		if (lim > accel)
			lim = accel;
		if (lim < decel)
			lim = decel;
		r.lim = lim[15:0];
		r.alim = accel[15:0];
		r.dlim = decel[15:0];
		r.nug = !found;
		r.act = held_act;
		return r;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// result side: check, then decide the stall for the next cycle
	always @(posedge clk) begin
		res_t e;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %0d", $time,
					limited_accel);
				errors++;
			end else begin
				e = result_q.pop_front();
				check_field("limited_accel", e.lim, limited_accel);
				check_field("accel_limit", e.alim, accel_limit);
				check_field("decel_limit", e.dlim, decel_limit);
				check_field("no_usable_gear", e.nug, no_usable_gear);
				check_field("acting_out", e.act, acting_out);
			end
		end
		if (hold_req) begin
			hold_req = 0;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle);
	end

	// offer one item and wait until it is taken
	task automatic send_item(item_t it, bit typed, res_t typed_res);
		res_t r;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		op <= it.op;
		gear_index <= it.idx;
		gear_ratio <= it.ratio;
		acting <= it.act;
		requested_accel <= it.req;
		velocity <= it.vel;
		road_friction <= it.fric;
		in_valid <= 1;
		do
			@(posedge clk);
		while (in_stall);
		r = limit_accel(it);
		result_q.insert(result_q.size(), typed ? typed_res : r);
		items_sent++;
	endtask

	// stop offering and let every pending result come out
	task automatic drain();
		in_valid <= 0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, longint val);
		int widths[8] = '{4, 16, 14, 14, 12, 16, 16, 15};
		cfg_reg[idx] = val & ((longint'(1) << widths[idx]) - 1);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= cfg_reg[idx][15:0];
		@(posedge clk);
		cfg_writes++;
	endtask

	// kind 0: all at top but min rpm, 1: all at bottom but min rpm, else a realistic random vehicle
	task automatic load_config(int kind);
		if (kind == 0) begin
			set_reg(CFG_GEAR_COUNT, 15);
			set_reg(CFG_AXLE_RADIUS, 65535);
			set_reg(CFG_MIN_RPM, 0);
			set_reg(CFG_MAX_RPM, 16383);
			set_reg(CFG_MAX_TORQUE, 4095);
			set_reg(CFG_MASS, 65535);
			set_reg(CFG_DRAG, 65535);
			set_reg(CFG_ROLLING, 32767);
		end else if (kind == 1) begin
			set_reg(CFG_GEAR_COUNT, 0);
			set_reg(CFG_AXLE_RADIUS, 0);
			set_reg(CFG_MIN_RPM, 16383);
			set_reg(CFG_MAX_RPM, 0);
			set_reg(CFG_MAX_TORQUE, 0);
			set_reg(CFG_MASS, 0);
			set_reg(CFG_DRAG, 0);
			set_reg(CFG_ROLLING, 0);
		end else begin
			set_reg(CFG_GEAR_COUNT, $urandom_range(1, 10));
			set_reg(CFG_AXLE_RADIUS, $urandom_range(512, 2048));
			set_reg(CFG_MIN_RPM, $urandom_range(500, 1500));
			set_reg(CFG_MAX_RPM, $urandom_range(5001, 8000));
			set_reg(CFG_MAX_TORQUE, $urandom_range(0, 4095));
			set_reg(CFG_MASS, $urandom_range(0, 4) == 0 ? $urandom_range(0, 65535)
				: $urandom_range(600, 3000));
			set_reg(CFG_DRAG, $urandom_range(0, 65535));
			set_reg(CFG_ROLLING, $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
				: $urandom_range(0, 300));
		end
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic item_t random_item();
		item_t it;
		int    pick;
		pick = $urandom_range(99);
		it.op = (pick < 15) ? OP_WRITE_GEAR : OP_COMPUTE;
		// gear writes: mostly valid entries, some ignored indexes
		it.idx = (pick < 10) ? 4'($urandom_range(1, TABLE_SIZE)) : 4'($urandom_range(0, 15));
		it.ratio = ($urandom_range(4) != 0) ? 16'($urandom_range(2000, 20000))
			: 16'($urandom_range(0, 65535));
		it.act = ($urandom_range(9) < 7);
		it.req = 16'($urandom_range(0, 65535));
		it.vel = ($urandom_range(4) != 0) ? 16'($urandom_range(0, 12000))
			: 16'($urandom_range(0, 65535));
		it.fric = 10'($urandom_range(0, 1023));
		return it;
	endfunction

	// directed rows; typed results only where they are plain
	row_t rows[] = '{
		'{'{OP_WRITE_GEAR, 1, 14745, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{OP_WRITE_GEAR, 2, 8602, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{OP_WRITE_GEAR, 3, 5980, 1, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{OP_WRITE_GEAR, 4, 4506, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{OP_WRITE_GEAR, 5, 3600, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{OP_WRITE_GEAR, 6, 3000, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{OP_WRITE_GEAR, 7, 2600, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{OP_WRITE_GEAR, 8, 65535, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		// ignored indexes
		'{'{OP_WRITE_GEAR, 0, 65535, 1, -1, 65535, 1023}, 1, '{0, 0, 0, 0, 0}},
		'{'{OP_WRITE_GEAR, 15, 0, 1, 32767, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		// standing still: no gear in range, limit is g
		'{'{OP_COMPUTE, 0, 0, 1, 32767, 0, 0}, 1, '{10045, 10045, 0, 1, 1}},
		'{'{OP_COMPUTE, 0, 0, 1, -32768, 0, 1023}, 1, '{-32768, 10045, -32768, 1, 1}},
		'{'{OP_COMPUTE, 0, 0, 0, 0, 0, 256}, 1, '{-10045, 10045, -10045, 1, 0}},
		// moving: gear curve in use
		'{'{OP_COMPUTE, 0, 0, 1, 1000, 5120, 200}, 0, '{0, 0, 0, 0, 0}},
		'{'{OP_COMPUTE, 0, 0, 1, 20000, 2560, 300}, 0, '{0, 0, 0, 0, 0}},
		'{'{OP_COMPUTE, 0, 0, 1, -500, 65535, 100}, 0, '{0, 0, 0, 0, 0}},
		'{'{OP_COMPUTE, 0, 0, 0, 777, 12800, 1023}, 0, '{0, 0, 0, 0, 0}},
		'{'{OP_WRITE_GEAR, 1, 40000, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
		'{'{OP_COMPUTE, 0, 0, 1, 32767, 1280, 512}, 0, '{0, 0, 0, 0, 0}}
	};

	// stimulus
	initial begin
		res_t none;
		none = '{default: '0};
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		cfg_writes = 0;
		cycles = 0;
		hold_cnt = 0;
		hold_req = 0;
		send_idle = 0;
		recv_idle = 0;
		held_req = 0;
		held_act = 0;
		cfg_reg = '{1, 1024, 800, 6000, 250, 1500, 205, 100};
		arst_n <= 0;
		in_valid <= 0;
		out_stall <= 0;
		op <= OP_COMPUTE;
		gear_index <= 0;
		gear_ratio <= 0;
		acting <= 0;
		requested_accel <= 0;
		velocity <= 0;
		road_friction <= 0;
		cfg_we <= 0;
		cfg_index <= CFG_GEAR_COUNT;
		cfg_data <= 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part on reset settings
		foreach (rows[i])
			send_item(rows[i].it, rows[i].typed, rows[i].res);
		drain();

		// random phases; sender-heavy, receiver-heavy, then free running
		for (int ph = 0; ph < 6; ph++) begin
			send_idle = (ph < 2) ? 11 : (ph < 4) ? 85 : 0;
			recv_idle = (ph < 2) ? 85 : (ph < 4) ? 11 : 0;
			load_config(ph == 1 ? 0 : ph == 3 ? 1 : 2);
			for (int n = 0; n < 80; n++) begin
				if (ph == 4 && n == 20)
					hold_req = 1;
				if (ph == 2 && n == 40)
					drain();
				send_item(random_item(), 0, none);
			end
			drain();
		end

		$display("Sent %0d items, checked %0d results, made %0d register writes",
			items_sent, results_seen, cfg_writes);
		$display("Covered gear writes, extreme and random vehicle settings, and stalls");
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
